@@ rtl/rwsc_pkg.sv @@
package rwsc_pkg;

  localparam int CHANNEL_BITS_DEF = 16;
  localparam int REG_BITS = 48;
  localparam int CODE_BITS = 16;
  localparam int INTERVAL_BITS = 32;
  localparam int INTERVAL_RESET = 500;
  localparam logic [3:0] CODE_OFF = 4'd10;

  typedef enum logic [2:0] {
    CLS_IDLE    = 3'd0,
    CLS_RUNNING = 3'd1,
    CLS_WARNING = 3'd2,
    CLS_ALARM   = 3'd3,
    CLS_UNKNOWN = 3'd4
  } class_t;

  typedef enum logic [2:0] {
    REG_RUNNING_TARGET = 3'd0,
    REG_IDLE_TARGET    = 3'd1,
    REG_WARNING_TARGET = 3'd2,
    REG_ALARM_TARGET   = 3'd3,
    REG_TOLERANCES     = 3'd4,
    REG_COLOUR_CODES   = 3'd5,
    REG_BLINK_INTERVAL = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] sample_red;
    logic [15:0] sample_green;
    logic [15:0] sample_blue;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [2:0] class_now;
    logic       class_changed;
    logic       detect_line;
    logic [3:0] colour_code;
    logic       indicator_red;
  } result_t;

  typedef struct packed {
    class_t      cls;
    logic [31:0] now_ms;
  } mid_t;

  typedef struct packed {
    logic [3:0][REG_BITS-1:0] targets;
    logic [REG_BITS-1:0]      tolerances;
  } front_cfg_t;

  typedef struct packed {
    logic [CODE_BITS-1:0]     colour_codes;
    logic [INTERVAL_BITS-1:0] blink_interval;
  } back_cfg_t;

endpackage

@@ rtl/rwsc_queue.sv @@
module rwsc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [1:0][WIDTH-1:0] store;
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ rtl/rwsc_front.sv @@
module rwsc_front #(
  parameter int CHANNEL_BITS = rwsc_pkg::CHANNEL_BITS_DEF
) (
  input  rwsc_pkg::sample_t    sample,
  input  rwsc_pkg::front_cfg_t cfg,
  output rwsc_pkg::mid_t       entry
);

  localparam int FW = 3 * CHANNEL_BITS;

  logic [2:0][CHANNEL_BITS-1:0] smp;
  logic [2:0][CHANNEL_BITS-1:0] tol;
  logic [3:0]                   hit;
  logic [CHANNEL_BITS+15:0]     red_ext;
  logic [CHANNEL_BITS+15:0]     green_ext;
  logic [CHANNEL_BITS+15:0]     blue_ext;
  logic [FW+rwsc_pkg::REG_BITS-1:0] tol_ext;
  logic [3:0][FW+rwsc_pkg::REG_BITS-1:0] tgt_ext;

  assign red_ext   = {{CHANNEL_BITS{1'b0}}, sample.sample_red};
  assign green_ext = {{CHANNEL_BITS{1'b0}}, sample.sample_green};
  assign blue_ext  = {{CHANNEL_BITS{1'b0}}, sample.sample_blue};
  assign smp[0]    = red_ext[CHANNEL_BITS-1:0];
  assign smp[1]    = green_ext[CHANNEL_BITS-1:0];
  assign smp[2]    = blue_ext[CHANNEL_BITS-1:0];
  assign tol_ext   = {{FW{1'b0}}, cfg.tolerances};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tol[c] = tol_ext[c*CHANNEL_BITS +: CHANNEL_BITS];
    end
  end

  always_comb begin
    logic [CHANNEL_BITS-1:0] t;
    logic [CHANNEL_BITS-1:0] d;
    for (int i = 0; i < 4; i++) begin
      tgt_ext[i] = {{FW{1'b0}}, cfg.targets[i]};
      hit[i] = 1'b1;
      for (int c = 0; c < 3; c++) begin
        t = tgt_ext[i][c*CHANNEL_BITS +: CHANNEL_BITS];
        d = (smp[c] > t) ? (smp[c] - t) : (t - smp[c]);
        if (d > tol[c]) begin
          hit[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    entry.now_ms = sample.now_ms;
    if (hit[0]) begin
      entry.cls = rwsc_pkg::CLS_RUNNING;
    end else if (hit[1]) begin
      entry.cls = rwsc_pkg::CLS_IDLE;
    end else if (hit[2]) begin
      entry.cls = rwsc_pkg::CLS_WARNING;
    end else if (hit[3]) begin
      entry.cls = rwsc_pkg::CLS_ALARM;
    end else begin
      entry.cls = rwsc_pkg::CLS_UNKNOWN;
    end
  end

endmodule

@@ rtl/rwsc_back.sv @@
module rwsc_back (
  input  logic                clk,
  input  logic                rst,
  input  rwsc_pkg::back_cfg_t cfg,
  input  rwsc_pkg::mid_t      entry,
  input  logic                entry_empty,
  output logic                entry_pop,
  output rwsc_pkg::result_t   result,
  output logic                result_push,
  input  logic                result_full
);

  rwsc_pkg::class_t cur_class;
  rwsc_pkg::class_t cur_class_next;
  logic             blink_phase;
  logic             blink_phase_next;
  logic [31:0]      last_toggle;
  logic [31:0]      last_toggle_next;
  logic             pixel_red;
  logic             pixel_red_next;
  logic             changed;
  logic [31:0]      elapsed;
  logic [3:0]       code_raw;
  logic             step;

  assign step        = !entry_empty && !result_full;
  assign entry_pop   = step;
  assign result_push = step;
  assign elapsed     = entry.now_ms - last_toggle;

  always_comb begin
    changed          = (entry.cls != cur_class);
    cur_class_next   = entry.cls;
    blink_phase_next = blink_phase;
    last_toggle_next = last_toggle;
    pixel_red_next   = changed ? 1'b0 : pixel_red;
    if (entry.cls == rwsc_pkg::CLS_UNKNOWN && elapsed > cfg.blink_interval) begin
      last_toggle_next = entry.now_ms;
      blink_phase_next = ~blink_phase;
      pixel_red_next   = ~blink_phase;
    end
  end

  always_comb begin
    unique case (entry.cls)
      rwsc_pkg::CLS_RUNNING: code_raw = cfg.colour_codes[3:0];
      rwsc_pkg::CLS_IDLE:    code_raw = cfg.colour_codes[7:4];
      rwsc_pkg::CLS_WARNING: code_raw = cfg.colour_codes[11:8];
      rwsc_pkg::CLS_ALARM:   code_raw = cfg.colour_codes[15:12];
      default:               code_raw = rwsc_pkg::CODE_OFF;
    endcase
  end

  always_comb begin
    result.class_now     = entry.cls;
    result.class_changed = changed;
    result.detect_line   = (entry.cls == rwsc_pkg::CLS_RUNNING);
    result.colour_code   = (code_raw > rwsc_pkg::CODE_OFF) ? rwsc_pkg::CODE_OFF : code_raw;
    result.indicator_red = pixel_red_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_class   <= rwsc_pkg::CLS_UNKNOWN;
      blink_phase <= 1'b0;
      last_toggle <= 32'd0;
      pixel_red   <= 1'b0;
    end else if (step) begin
      cur_class   <= cur_class_next;
      blink_phase <= blink_phase_next;
      last_toggle <= last_toggle_next;
      pixel_red   <= pixel_red_next;
    end
  end

endmodule

@@ rtl/rgb_window_state_classifier.sv @@
// Channel    Handshake           Payload
// sample     push / full         rwsc_pkg::sample_t (RGB reading, now_ms)
// result     pop / empty         rwsc_pkg::result_t (class, flags, colour code)
// config     cfg_write           cfg_index (3 bits), cfg_data (48 bits)
//
// One item per cycle sustained while the result side keeps popping; a result
// is held in the mid queue, then in the result queue, before it can be popped.
// The front classifies in the accept cycle; the back updates state one item a
// cycle, unless the two-entry result queue is full, from a two-entry queue.
// Reset sets the class to unknown, clears blink state, interval to 500 ms.
// A stalled result side fills both queues, then full rises.
module rgb_window_state_classifier #(
  parameter int CHANNEL_BITS = rwsc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  rwsc_pkg::sample_t   sample,
  input  logic                pop,
  output logic                empty,
  output rwsc_pkg::result_t   result,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [rwsc_pkg::REG_BITS-1:0] cfg_data
);

  rwsc_pkg::front_cfg_t front_cfg;
  rwsc_pkg::back_cfg_t  back_cfg;
  rwsc_pkg::mid_t       front_entry;
  rwsc_pkg::mid_t       mid_entry;
  logic                 mid_empty;
  logic                 mid_pop;
  rwsc_pkg::result_t    back_result;
  logic                 back_push;
  logic                 out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_cfg               <= '0;
      back_cfg.colour_codes   <= '0;
      back_cfg.blink_interval <= rwsc_pkg::INTERVAL_BITS'(rwsc_pkg::INTERVAL_RESET);
    end else if (cfg_write) begin
      unique case (rwsc_pkg::cfg_idx_t'(cfg_index))
        rwsc_pkg::REG_RUNNING_TARGET: front_cfg.targets[0] <= cfg_data;
        rwsc_pkg::REG_IDLE_TARGET:    front_cfg.targets[1] <= cfg_data;
        rwsc_pkg::REG_WARNING_TARGET: front_cfg.targets[2] <= cfg_data;
        rwsc_pkg::REG_ALARM_TARGET:   front_cfg.targets[3] <= cfg_data;
        rwsc_pkg::REG_TOLERANCES:     front_cfg.tolerances <= cfg_data;
        rwsc_pkg::REG_COLOUR_CODES:
          back_cfg.colour_codes <= cfg_data[rwsc_pkg::CODE_BITS-1:0];
        rwsc_pkg::REG_BLINK_INTERVAL:
          back_cfg.blink_interval <= cfg_data[rwsc_pkg::INTERVAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  rwsc_front #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_front (
    .sample(sample),
    .cfg   (front_cfg),
    .entry (front_entry)
  );

  rwsc_queue #(
    .WIDTH($bits(rwsc_pkg::mid_t))
  ) u_mid_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(front_entry),
    .full (full),
    .pop  (mid_pop),
    .rdata(mid_entry),
    .empty(mid_empty)
  );

  rwsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (back_cfg),
    .entry      (mid_entry),
    .entry_empty(mid_empty),
    .entry_pop  (mid_pop),
    .result     (back_result),
    .result_push(back_push),
    .result_full(out_full)
  );

  rwsc_queue #(
    .WIDTH($bits(rwsc_pkg::result_t))
  ) u_out_queue (
    .clk  (clk),
    .rst  (rst),
    .push (back_push),
    .wdata(back_result),
    .full (out_full),
    .pop  (pop),
    .rdata(result),
    .empty(empty)
  );

endmodule

@@ verif/rgb_window_state_classifier_tb.sv @@
module rgb_window_state_classifier_tb;
  import rwsc_pkg::*;

  localparam int DIR_COUNT = 23;
  localparam int PHASE_ITEMS = 75;
  localparam int RANDOM_PHASES = 6;
  localparam int SETTLE_LIMIT = 5000;

  typedef struct packed {
    logic [1:0] set;
    sample_t    smp;
    logic       typed;
    result_t    want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  sample_t sample_in;
  logic pop;
  logic empty;
  result_t result_out;
  logic cfg_write;
  logic [2:0] cfg_index;
  logic [REG_BITS-1:0] cfg_data;

  // classifier shadow: settings and state
  logic [3:0][REG_BITS-1:0] target_reg;
  logic [REG_BITS-1:0] tol_reg;
  logic [CODE_BITS-1:0] codes_reg;
  logic [INTERVAL_BITS-1:0] interval_reg;
  class_t cur_class;
  logic blink_phase;
  logic [31:0] last_toggle;
  logic pixel_red;

  result_t expected_q[$];
  logic [31:0] clock_ms;
  bit send_idle_en;
  bit drain_idle_en;
  int pop_hold = 0;
  int errors = 0;
  int items_sent = 0;
  int items_typed = 0;
  int results_seen = 0;
  int settings_applied = 0;
  int toggles = 0;
  int changes = 0;
  int class_seen[5] = '{0, 0, 0, 0, 0};

  dir_row_t dir_rows [DIR_COUNT] = '{
    '{2'd0, '{16'h0000, 16'h0000, 16'h0000, 32'd0}, 1'b1,
      '{CLS_RUNNING, 1'b1, 1'b1, 4'd0, 1'b0}},
    '{2'd0, '{16'h0000, 16'h0000, 16'h0000, 32'd10}, 1'b1,
      '{CLS_RUNNING, 1'b0, 1'b1, 4'd0, 1'b0}},
    '{2'd0, '{16'h0001, 16'h0000, 16'h0000, 32'd20}, 1'b1,
      '{CLS_UNKNOWN, 1'b1, 1'b0, CODE_OFF, 1'b0}},
    '{2'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd501}, 1'b1,
      '{CLS_UNKNOWN, 1'b0, 1'b0, CODE_OFF, 1'b1}},
    '{2'd0, '{16'hFFFF, 16'h0000, 16'hFFFF, 32'd1001}, 1'b1,
      '{CLS_UNKNOWN, 1'b0, 1'b0, CODE_OFF, 1'b1}},
    '{2'd0, '{16'h0000, 16'hFFFF, 16'h0000, 32'd1002}, 1'b1,
      '{CLS_UNKNOWN, 1'b0, 1'b0, CODE_OFF, 1'b0}},
    '{2'd0, '{16'h0000, 16'h0000, 16'h0001, 32'hFFFF_FFFF}, 1'b1,
      '{CLS_UNKNOWN, 1'b0, 1'b0, CODE_OFF, 1'b1}},
    '{2'd0, '{16'h0000, 16'h0001, 16'h0000, 32'd499}, 1'b1,
      '{CLS_UNKNOWN, 1'b0, 1'b0, CODE_OFF, 1'b1}},
    '{2'd0, '{16'h0000, 16'h0001, 16'h0000, 32'd500}, 1'b1,
      '{CLS_UNKNOWN, 1'b0, 1'b0, CODE_OFF, 1'b0}},
    '{2'd0, '{16'h0000, 16'h0000, 16'h0000, 32'd600}, 1'b1,
      '{CLS_RUNNING, 1'b1, 1'b1, 4'd0, 1'b0}},
    '{2'd1, '{16'd100, 16'd200, 16'd300, 32'd700}, 1'b0, '0},
    '{2'd1, '{16'd110, 16'd220, 16'd330, 32'd701}, 1'b0, '0},
    '{2'd1, '{16'd111, 16'd200, 16'd300, 32'd702}, 1'b0, '0},
    '{2'd1, '{16'd90, 16'd180, 16'd270, 32'd702}, 1'b0, '0},
    '{2'd1, '{16'd1000, 16'd1000, 16'd1000, 32'd703}, 1'b0, '0},
    '{2'd1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd704}, 1'b0, '0},
    '{2'd1, '{16'hFFF5, 16'hFFEB, 16'hFFE1, 32'd705}, 1'b0, '0},
    '{2'd1, '{16'd0, 16'd0, 16'd0, 32'd706}, 1'b0, '0},
    '{2'd1, '{16'd10, 16'd20, 16'd30, 32'd707}, 1'b0, '0},
    '{2'd1, '{16'd10, 16'd20, 16'd31, 32'd708}, 1'b0, '0},
    '{2'd1, '{16'd10, 16'd20, 16'd31, 32'd708}, 1'b0, '0},
    '{2'd1, '{16'd10, 16'd20, 16'd31, 32'd709}, 1'b0, '0},
    '{2'd1, '{16'd89, 16'd200, 16'd300, 32'd710}, 1'b0, '0}
  };

  rgb_window_state_classifier i_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .sample   (sample_in),
    .pop      (pop),
    .empty    (empty),
    .result   (result_out),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic flag_error(input string msg);
    errors++;
    $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit in_window(sample_t s, logic [REG_BITS-1:0] tgt);
    logic [2:0][15:0] ch;
    logic [15:0] t;
    logic [15:0] tol;
    logic [15:0] d;
    ch = {s.sample_blue, s.sample_green, s.sample_red};
    for (int c = 0; c < 3; c++) begin
      t = tgt[16*c +: 16];
      tol = tol_reg[16*c +: 16];
      d = (ch[c] > t) ? ch[c] - t : t - ch[c];
      if (d > tol) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic class_t slot_class(int slot);
    case (slot)
      0: return CLS_RUNNING;
      1: return CLS_IDLE;
      2: return CLS_WARNING;
      default: return CLS_ALARM;
    endcase
  endfunction

  // advance the shadow state by one sample and return the result it gives
  function automatic result_t classify_sample(sample_t s);
    result_t r;
    class_t found;
    int slot;
    logic [3:0] code;
    logic [31:0] elapsed;
    found = CLS_UNKNOWN;
    slot = 0;
    for (int i = 0; i < 4; i++) begin
      if (found == CLS_UNKNOWN && in_window(s, target_reg[i])) begin
        found = slot_class(i);
        slot = i;
      end
    end
    r.class_changed = (found != cur_class);
    if (found != cur_class) begin
      cur_class = found;
      pixel_red = 1'b0;
    end
    code = CODE_OFF;
    if (cur_class == CLS_UNKNOWN) begin
      elapsed = s.now_ms - last_toggle;
      if (elapsed > interval_reg) begin
        last_toggle = s.now_ms;
        blink_phase = ~blink_phase;
        pixel_red = blink_phase;
        toggles++;
      end
    end else begin
      code = codes_reg[4*slot +: 4];
      if (code > CODE_OFF) code = CODE_OFF;
    end
    r.class_now = cur_class;
    r.detect_line = (cur_class == CLS_RUNNING);
    r.colour_code = code;
    r.indicator_red = pixel_red;
    return r;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [REG_BITS-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_RUNNING_TARGET: target_reg[0] = val;
      REG_IDLE_TARGET:    target_reg[1] = val;
      REG_WARNING_TARGET: target_reg[2] = val;
      REG_ALARM_TARGET:   target_reg[3] = val;
      REG_TOLERANCES:     tol_reg = val;
      REG_COLOUR_CODES:   codes_reg = val[CODE_BITS-1:0];
      REG_BLINK_INTERVAL: interval_reg = val[INTERVAL_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic apply_settings(input logic [3:0][REG_BITS-1:0] tgts,
                                input logic [REG_BITS-1:0] tol,
                                input logic [CODE_BITS-1:0] codes,
                                input logic [INTERVAL_BITS-1:0] interval);
    write_reg(REG_RUNNING_TARGET, tgts[0]);
    write_reg(REG_IDLE_TARGET, tgts[1]);
    write_reg(REG_WARNING_TARGET, tgts[2]);
    write_reg(REG_ALARM_TARGET, tgts[3]);
    write_reg(REG_TOLERANCES, tol);
    write_reg(REG_COLOUR_CODES, {{(REG_BITS-CODE_BITS){1'b0}}, codes});
    write_reg(REG_BLINK_INTERVAL, {{(REG_BITS-INTERVAL_BITS){1'b0}}, interval});
    settings_applied++;
  endtask

  function automatic logic [15:0] rand_tol();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'($urandom_range(0, 64));
      2: return 16'($urandom_range(0, 4095));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic randomize_settings(input int phase);
    logic [3:0][REG_BITS-1:0] tgts;
    logic [REG_BITS-1:0] tol;
    logic [INTERVAL_BITS-1:0] interval;
    if (phase == 0) begin
      apply_settings({4{48'hFFFF_FFFF_FFFF}}, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    end else if (phase == 1) begin
      apply_settings('0, '0, '0, '0);
    end else begin
      for (int i = 0; i < 4; i++) begin
        tgts[i] = REG_BITS'({$urandom, $urandom});
      end
      if ($urandom_range(0, 2) == 0) begin
        tgts[$urandom_range(1, 3)] = tgts[$urandom_range(0, 2)];
      end
      tol = {rand_tol(), rand_tol(), rand_tol()};
      case ($urandom_range(0, 3))
        0: interval = '0;
        1: interval = $urandom_range(1, 40);
        2: interval = $urandom_range(41, 1000);
        default: interval = $urandom;
      endcase
      apply_settings(tgts, tol, 16'($urandom), interval);
    end
  endtask

  function automatic logic [15:0] near(logic [15:0] t, logic [15:0] tol);
    int off;
    off = $urandom_range(0, int'(tol) + 1);
    if ($urandom_range(0, 1) == 1) return t + 16'(off);
    return t - 16'(off);
  endfunction

  function automatic sample_t make_sample();
    sample_t s;
    logic [REG_BITS-1:0] tgt;
    if ($urandom_range(0, 9) == 0) begin
      clock_ms = $urandom;
    end else begin
      clock_ms = clock_ms + $urandom_range(0, 30);
    end
    if ($urandom_range(0, 3) == 0) begin
      s.sample_red = 16'($urandom);
      s.sample_green = 16'($urandom);
      s.sample_blue = 16'($urandom);
    end else begin
      tgt = target_reg[$urandom_range(0, 3)];
      s.sample_red = near(tgt[15:0], tol_reg[15:0]);
      s.sample_green = near(tgt[31:16], tol_reg[31:16]);
      s.sample_blue = near(tgt[47:32], tol_reg[47:32]);
    end
    s.now_ms = clock_ms;
    return s;
  endfunction

  task automatic send_sample(input sample_t s, input logic typed, input result_t want);
    result_t pred;
    int gap;
    gap = send_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    sample_in = s;
    do @(posedge clk); while (full);
    pred = classify_sample(s);
    expected_q.push_back(typed ? want : pred);
    items_sent++;
    if (typed) items_typed++;
    @(negedge clk);
  endtask

  // hold until every expected result has come, then let the pipe go quiet
  task automatic settle();
    int waited;
    push = 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (expected_q.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_q.size()));
      expected_q.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      flag_error($sformatf("result %0d %s: got %0d, expected %0d",
                           results_seen, name, got, want));
    end
  endtask

  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop = 1'b0;
      pop_hold = pop_hold - 1;
    end else begin
      pop = 1'b1;
      if (drain_idle_en) pop_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) begin
        flag_error($sformatf("result with nothing expected: class %0d",
                             result_out.class_now));
      end else begin
        want = expected_q.pop_front();
        check_field("class_now", result_out.class_now, want.class_now);
        check_field("class_changed", result_out.class_changed, want.class_changed);
        check_field("detect_line", result_out.detect_line, want.detect_line);
        check_field("colour_code", result_out.colour_code, want.colour_code);
        check_field("indicator_red", result_out.indicator_red, want.indicator_red);
        if (want.class_now <= CLS_UNKNOWN) class_seen[want.class_now]++;
        if (want.class_changed) changes++;
        results_seen++;
      end
    end
  end

  initial begin
    int cur_set;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    sample_in = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    target_reg = '0;
    tol_reg = '0;
    codes_reg = '0;
    interval_reg = INTERVAL_RESET;
    cur_class = CLS_UNKNOWN;
    blink_phase = 1'b0;
    last_toggle = '0;
    pixel_red = 1'b0;
    clock_ms = '0;
    send_idle_en = 1'b1;
    drain_idle_en = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    cur_set = 0;
    for (int i = 0; i < DIR_COUNT; i++) begin
      if (dir_rows[i].set != cur_set) begin
        settle();
        apply_settings({48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF,
                        48'h03E8_03E8_03E8, 48'h012C_00C8_0064},
                       48'h001E_0014_000A, 16'h7FC3, 32'd0);
        cur_set = dir_rows[i].set;
      end
      send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      randomize_settings(p);
      send_idle_en = (p % 3 != 2);
      drain_idle_en = (p % 3 != 1);
      repeat (PHASE_ITEMS) send_sample(make_sample(), 1'b0, '0);
    end

    settle();
    repeat (10) @(negedge clk);
    $display("Sent %0d samples (%0d with typed results) under %0d register settings;",
             items_sent, items_typed, settings_applied + 1);
    $display("%0d results checked; classes idle %0d running %0d warning %0d alarm %0d",
             results_seen, class_seen[CLS_IDLE], class_seen[CLS_RUNNING],
             class_seen[CLS_WARNING], class_seen[CLS_ALARM]);
    $display("unknown %0d, %0d changes, %0d blinks",
             class_seen[CLS_UNKNOWN], changes, toggles);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
